/* rtl/core/bitmap_frame_allocator_unit_assert.svh */
// Assertion macros used by the checker file.
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bfa_pkg.sv */
package bfa_pkg;

    localparam int WORD_BITS        = 32;
    localparam int WORD_SHIFT       = 5;
    localparam int FRAME_W          = 21;
    localparam int BITMAP_WORDS_DEF = 32768;
    localparam int IN_W             = 72;
    localparam int OUT_W            = 56;

    localparam logic [FRAME_W-1:0] COUNT_MAX = {FRAME_W{1'b1}};

    // Input opcodes.
    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_FREE    = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_RESERVE = 3'd3;
    localparam logic [2:0] OP_INIT    = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // Command kinds after classification.
    localparam logic [2:0] K_NOP   = 3'd0;
    localparam logic [2:0] K_ERR   = 3'd1;
    localparam logic [2:0] K_ALLOC = 3'd2;
    localparam logic [2:0] K_CLR   = 3'd3;
    localparam logic [2:0] K_SET   = 3'd4;
    localparam logic [2:0] K_INIT  = 3'd5;

    typedef struct packed {
        logic [2:0]         kind;
        logic [FRAME_W-1:0] first;
        logic [FRAME_W-1:0] last;
    } bfa_cmd_t;

endpackage

/* rtl/core/bfa_ram.sv */
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32768
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/bfa_front.sv */
module bfa_front (
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [bfa_pkg::IN_W-1:0]  s_tdata,
    input  logic [bfa_pkg::FRAME_W-1:0] total,
    input  logic                      q_full,
    output logic                      q_push,
    output bfa_pkg::bfa_cmd_t         q_data
);
    import bfa_pkg::*;

    logic [2:0]         opcode;
    logic [31:0]        base;
    logic [31:0]        size;
    logic [FRAME_W-1:0] first_f;
    logic [19:0]        rel_n;
    logic [21:0]        rel_end;
    logic [33:0]        res_sum;
    logic [21:0]        end_sel;
    logic [FRAME_W-1:0] end_c;
    logic               empty;

    assign opcode  = s_tdata[2:0];
    assign base    = s_tdata[34:3];
    assign size    = s_tdata[66:35];
    assign first_f = FRAME_W'(base[31:12]);

    // A nonzero region shorter than one frame still covers one frame.
    assign rel_n   = (size[31:12] == 20'd0 && size != 32'd0) ? 20'd1 : size[31:12];
    assign rel_end = {2'b00, base[31:12]} + {2'b00, rel_n};
    // Reserve rounds the region end up to the next frame boundary.
    assign res_sum = {2'b00, base} + {2'b00, size} + 34'd4095;
    assign end_sel = (opcode == OP_RESERVE) ? res_sum[33:12] : rel_end;
    assign end_c   = (end_sel > {1'b0, total}) ? total : end_sel[FRAME_W-1:0];
    assign empty   = first_f >= end_c;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_data.kind  = K_NOP;
        q_data.first = first_f;
        q_data.last  = end_c - FRAME_W'(1);
        case (opcode)
            OP_ALLOC:
            begin
                q_data.kind  = K_ALLOC;
                q_data.first = '0;
                q_data.last  = total - FRAME_W'(1);
            end
            OP_FREE:
            begin
                q_data.kind = (first_f >= total) ? K_ERR : K_CLR;
                q_data.last = first_f;
            end
            OP_RELEASE:
            begin
                q_data.kind = empty ? K_NOP : K_CLR;
            end
            OP_RESERVE:
            begin
                q_data.kind = empty ? K_NOP : K_SET;
            end
            OP_INIT:
            begin
                q_data.kind = K_INIT;
            end
            default:
            begin
                q_data.kind = K_NOP;
            end
        endcase
    end

endmodule

/* rtl/core/bfa_cmdq.sv */
module bfa_cmdq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bfa_pkg::bfa_cmd_t push_data,
    output logic              full,
    input  logic              pop,
    output bfa_pkg::bfa_cmd_t pop_data,
    output logic              valid
);
    import bfa_pkg::*;

    bfa_cmd_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full     = cnt_reg == 2'd2;
    assign valid    = cnt_reg != 2'd0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* rtl/core/bfa_back.sv */
module bfa_back #(
    parameter int BITMAP_WORDS = bfa_pkg::BITMAP_WORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [bfa_pkg::FRAME_W-1:0] total,
    input  logic                        cmd_valid,
    input  bfa_pkg::bfa_cmd_t           cmd,
    output logic                        cmd_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bfa_pkg::OUT_W-1:0]   m_tdata
);
    import bfa_pkg::*;

    localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam logic [AW-1:0] LAST_WORD = AW'(BITMAP_WORDS - 1);
    localparam logic [WORD_SHIFT-1:0] TOP_BIT = WORD_SHIFT'(WORD_BITS - 1);
    localparam logic [WORD_BITS-1:0] ALL = {WORD_BITS{1'b1}};

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RUN    = 2'd1;
    localparam logic [1:0] S_INIT   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]            state_reg,    state_next;
    logic [2:0]            kind_reg,     kind_next;
    logic [AW-1:0]         wfirst_reg,   wfirst_next;
    logic [AW-1:0]         wlast_reg,    wlast_next;
    logic [WORD_SHIFT-1:0] bfirst_reg,   bfirst_next;
    logic [WORD_SHIFT-1:0] blast_reg,    blast_next;
    logic [AW-1:0]         ptr_reg,      ptr_next;
    logic                  issuing_reg,  issuing_next;
    logic                  pend_reg,     pend_next;
    logic [AW-1:0]         proc_reg,     proc_next;
    logic [FRAME_W-1:0]    count_reg,    count_next;
    logic [1:0]            rstat_reg,    rstat_next;
    logic [31:0]           raddr_reg,    raddr_next;
    logic                  mvalid_reg,   mvalid_next;
    logic [OUT_W-1:0]      mdata_reg,    mdata_next;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [WORD_BITS-1:0]  wdata;
    logic [AW-1:0]         raddr;
    logic [WORD_BITS-1:0]  rdata;

    logic [FRAME_W-1:0]    free_cnt;
    logic [WORD_BITS-1:0]  mask;
    logic [WORD_BITS-1:0]  avail;
    logic [WORD_SHIFT-1:0] sel;
    logic [WORD_SHIFT:0]   delta;
    logic [FRAME_W:0]      inc_sum;
    logic [FRAME_W-1:0]    frame;

    bfa_ram #(.WIDTH(WORD_BITS), .DEPTH(BITMAP_WORDS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign free_cnt = (total > count_reg) ? total - count_reg : '0;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    always_comb
    begin
        mask = ALL;
        if (proc_reg == wfirst_reg)
        begin
            mask = mask & (ALL << bfirst_reg);
        end
        if (proc_reg == wlast_reg)
        begin
            mask = mask & (ALL >> (TOP_BIT - blast_reg));
        end
        avail = ~rdata & mask;
        sel = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (avail[j])
            begin
                sel = WORD_SHIFT'(j);
            end
        end
        frame = (FRAME_W'(proc_reg) << WORD_SHIFT) | FRAME_W'(sel);
    end

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        wfirst_next  = wfirst_reg;
        wlast_next   = wlast_reg;
        bfirst_next  = bfirst_reg;
        blast_next   = blast_reg;
        ptr_next     = ptr_reg;
        issuing_next = issuing_reg;
        pend_next    = 1'b0;
        proc_next    = proc_reg;
        count_next   = count_reg;
        rstat_next   = rstat_reg;
        raddr_next   = raddr_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mdata_next   = mdata_reg;
        cmd_pop      = 1'b0;
        we           = 1'b0;
        waddr        = proc_reg;
        wdata        = rdata;
        raddr        = ptr_reg;
        delta        = '0;
        inc_sum      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop      = 1'b1;
                    kind_next    = cmd.kind;
                    wfirst_next  = AW'(cmd.first >> WORD_SHIFT);
                    wlast_next   = AW'(cmd.last >> WORD_SHIFT);
                    bfirst_next  = cmd.first[WORD_SHIFT-1:0];
                    blast_next   = cmd.last[WORD_SHIFT-1:0];
                    ptr_next     = AW'(cmd.first >> WORD_SHIFT);
                    issuing_next = 1'b1;
                    rstat_next   = ST_OK;
                    raddr_next   = '0;
                    case (cmd.kind)
                        K_ALLOC:
                        begin
                            if (free_cnt == '0)
                            begin
                                rstat_next = ST_NOFREE;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_RUN;
                            end
                        end
                        K_CLR, K_SET:
                        begin
                            state_next = S_RUN;
                        end
                        K_INIT:
                        begin
                            ptr_next   = '0;
                            state_next = S_INIT;
                        end
                        K_ERR:
                        begin
                            rstat_next = ST_RANGE;
                            state_next = S_RESULT;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                // Reads go out one word a cycle; each word is checked, and updated if needed, the cycle after.
                if (issuing_reg)
                begin
                    pend_next = 1'b1;
                    proc_next = ptr_reg;
                    if (ptr_reg == wlast_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
                if (pend_reg)
                begin
                    if (kind_reg == K_ALLOC)
                    begin
                        if (avail != '0)
                        begin
                            we         = 1'b1;
                            wdata      = rdata | (WORD_BITS'(1) << sel);
                            count_next = (count_reg == COUNT_MAX) ? count_reg
                                                                  : count_reg + FRAME_W'(1);
                            raddr_next = {frame[19:0], 12'd0};
                            state_next = S_RESULT;
                        end
                        else if (proc_reg == wlast_reg)
                        begin
                            rstat_next = ST_NOFREE;
                            state_next = S_RESULT;
                        end
                    end
                    else
                    begin
                        we    = 1'b1;
                        wdata = (kind_reg == K_SET) ? (rdata | mask) : (rdata & ~mask);
                        delta = (WORD_SHIFT + 1)'($countones(rdata ^ wdata));
                        if (kind_reg == K_SET)
                        begin
                            inc_sum    = {1'b0, count_reg} + (FRAME_W + 1)'(delta);
                            count_next = inc_sum[FRAME_W] ? COUNT_MAX : inc_sum[FRAME_W-1:0];
                        end
                        else
                        begin
                            count_next = (count_reg > FRAME_W'(delta))
                                         ? count_reg - FRAME_W'(delta) : '0;
                        end
                        if (proc_reg == wlast_reg)
                        begin
                            state_next = S_RESULT;
                        end
                    end
                    if (state_next == S_RESULT)
                    begin
                        issuing_next = 1'b0;
                        pend_next    = 1'b0;
                    end
                end
            end
            S_INIT:
            begin
                we    = 1'b1;
                waddr = ptr_reg;
                wdata = ALL;
                if (ptr_reg == LAST_WORD)
                begin
                    count_next = total;
                    state_next = S_RESULT;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            S_RESULT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {1'b0, free_cnt, raddr_reg, rstat_reg};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        wfirst_reg <= wfirst_next;
        wlast_reg  <= wlast_next;
        bfirst_reg <= bfirst_next;
        blast_reg  <= blast_next;
        ptr_reg    <= ptr_next;
        proc_reg   <= proc_next;
        rstat_reg  <= rstat_next;
        raddr_reg  <= raddr_next;
        mdata_reg  <= mdata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            issuing_reg <= 1'b0;
            pend_reg    <= 1'b0;
            count_reg   <= '0;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            issuing_reg <= issuing_next;
            pend_reg    <= pend_next;
            count_reg   <= count_next;
            mvalid_reg  <= mvalid_next;
        end
    end

endmodule

/* rtl/core/bitmap_frame_allocator_unit.sv */
// Channel    Dir  Width  Contents (low bit first)
// s_*        in   72     opcode[2:0], base_address[34:3], region_size[66:35]
// m_*        out  56     status[1:0], frame_address[33:2], free_frames[54:34]
// cfg_*      in   21     total_frames, written when cfg_wr_en is high
//
// Allocate reads one bitmap word per cycle through the single-port-pair bitmap RAM
// and stops at the first free frame.
// Region operations read and update each bitmap word they touch; free touches one word.
// Initialize writes every word once and must precede use.
// Reset clears the used count and control state only; the bitmap holds no reset value.
// A two-entry command queue lets the input side take transfers while the engine works.
module bitmap_frame_allocator_unit #(
    parameter int BITMAP_WORDS = bfa_pkg::BITMAP_WORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // opcode, base_address, region_size, zero fill
    input  logic [bfa_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // status, frame_address, free_frames, zero fill
    output logic [bfa_pkg::OUT_W-1:0]   m_tdata,
    input  logic                        cfg_wr_en,
    input  logic [bfa_pkg::FRAME_W-1:0] cfg_wr_data
);
    import bfa_pkg::*;

    // The effective total is capped by the bitmap capacity, which by default equals
    // the 1M frames a 32-bit address space holds.
    localparam logic [FRAME_W-1:0] CAPACITY = FRAME_W'(BITMAP_WORDS * WORD_BITS);

    logic [FRAME_W-1:0] total_frames_reg;
    logic [FRAME_W-1:0] total_frames_next;
    logic [FRAME_W-1:0] eff_total;

    logic     q_full;
    logic     q_push;
    bfa_cmd_t q_in;
    logic     q_pop;
    bfa_cmd_t q_out;
    logic     q_valid;

    assign total_frames_next = cfg_wr_en ? cfg_wr_data : total_frames_reg;
    assign eff_total = (total_frames_reg > CAPACITY) ? CAPACITY : total_frames_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_frames_reg <= '0;
        end
        else
        begin
            total_frames_reg <= total_frames_next;
        end
    end

    // Front end: decodes each transfer into a frame range and a command kind.
    bfa_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .total    (eff_total),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    bfa_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .valid     (q_valid)
    );

    // Back end: walks the bitmap words and owns the result register.
    bfa_back #(.BITMAP_WORDS(BITMAP_WORDS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .total     (eff_total),
        .cmd_valid (q_valid),
        .cmd       (q_out),
        .cmd_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* rtl/core/bfa_checker.sv */
`include "bitmap_frame_allocator_unit_assert.svh"

module bfa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bfa_pkg::OUT_W-1:0]   m_tdata
);
    import bfa_pkg::*;

    `BFA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `BFA_ASSERT_NOW(a_status_code, m_tvalid, m_tdata[1:0] != 2'd3, "undefined status code")
    `BFA_ASSERT_NOW(a_addr_zero, m_tvalid && m_tdata[1:0] != ST_OK, m_tdata[33:2] == 32'd0, "address on failed result")
    `BFA_ASSERT_NOW(a_addr_align, m_tvalid, m_tdata[13:2] == 12'd0 && m_tdata[55] == 1'b0, "address not frame aligned")

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
);

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import bfa_pkg::*;

    // Opcodes that the block leaves without effect.
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    localparam int unsigned FRAME_CAPACITY = BITMAP_WORDS_DEF * WORD_BITS;
    localparam int unsigned PAGE_BYTES     = 4096;
    localparam longint unsigned CYCLE_LIMIT = 4_000_000;

    typedef struct {
        logic [1:0]         status;
        logic [31:0]        frame_address;
        logic [FRAME_W-1:0] free_frames;
    } alloc_result_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // opcode, base_address, region_size, zero fill
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    // status, frame_address, free_frames, zero fill
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_wr_en;
    logic [FRAME_W-1:0]  cfg_wr_data;

    // Predictor state: one bit per frame, the used count and the total register.
    bit                  frame_used [0:FRAME_CAPACITY-1];
    logic [FRAME_W-1:0]  used_cnt;
    logic [FRAME_W-1:0]  total_reg;

    alloc_result_t       pending_results[$];
    int                  err_count;
    longint unsigned     cycle_count;
    int                  tx_idle_pct;
    int                  rx_idle_pct;
    int                  rx_hold_cycles;

    bitmap_frame_allocator_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic int unsigned usable_frames();
        int unsigned t;
        t = total_reg;
        if (t > FRAME_CAPACITY)
        begin
            t = FRAME_CAPACITY;
        end
        return t;
    endfunction

    // Frames at or beyond the total are left alone; the count follows real changes only.
    function automatic void put_frame(longint unsigned f, bit val);
        if (f >= usable_frames())
        begin
            return;
        end
        if (val && !frame_used[f])
        begin
            frame_used[f] = 1'b1;
            if (used_cnt != COUNT_MAX)
            begin
                used_cnt = used_cnt + 1'b1;
            end
        end
        else if (!val && frame_used[f])
        begin
            frame_used[f] = 1'b0;
            if (used_cnt != '0)
            begin
                used_cnt = used_cnt - 1'b1;
            end
        end
    endfunction

    function automatic void mark_span(longint unsigned first, longint unsigned stop, bit val);
        longint unsigned f;
        if (stop > usable_frames())
        begin
            stop = usable_frames();
        end
        for (f = first; f < stop; f++)
        begin
            put_frame(f, val);
        end
    endfunction

    // Applies one command to the frame map and returns the answer the block owes.
    function automatic alloc_result_t predict_allocation(logic [2:0] op, logic [31:0] base,
                                                         logic [31:0] size);
        alloc_result_t   r;
        longint unsigned first;
        longint unsigned span;
        int unsigned     t;
        int unsigned     i;
        bit              found;
        r.status        = ST_OK;
        r.frame_address = '0;
        first = base >> 12;
        t     = usable_frames();
        found = 1'b0;
        case (op)
            OP_ALLOC:
            begin
                r.status = ST_NOFREE;
                if (t > used_cnt)
                begin
                    for (i = 0; i < t && !found; i++)
                    begin
                        if (!frame_used[i])
                        begin
                            put_frame(i, 1'b1);
                            r.frame_address = i * PAGE_BYTES;
                            r.status        = ST_OK;
                            found           = 1'b1;
                        end
                    end
                end
            end
            OP_FREE:
            begin
                if (first >= t)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    put_frame(first, 1'b0);
                end
            end
            OP_RELEASE:
            begin
                span = size >> 12;
                if (span == 0 && size != 0)
                begin
                    span = 1;
                end
                mark_span(first, first + span, 1'b0);
            end
            OP_RESERVE:
            begin
                // The end is rounded up and formed in 64 bits, so it never wraps.
                span = (longint'(base) + longint'(size) + PAGE_BYTES - 1) >> 12;
                mark_span(first, span, 1'b1);
            end
            OP_INIT:
            begin
                foreach (frame_used[k])
                begin
                    frame_used[k] = 1'b1;
                end
                used_cnt = FRAME_W'(t);
            end
            default:
            begin
            end
        endcase
        r.free_frames = (t > used_cnt) ? FRAME_W'(t - used_cnt) : '0;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    // Offers one command, predicting its answer, and returns once it is accepted.
    task automatic send_command(logic [2:0] op, logic [31:0] base, logic [31:0] size);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, size, base, op};
        pending_results.push_back(predict_allocation(op, base, size));
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    // Every command answers once, so an empty queue means the block is idle.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_total(logic [FRAME_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        total_reg    = value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Receiver: random stalls, or a long hold-off while the count runs down.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Result checker: each transfer is compared with the oldest prediction.
    always @(posedge clk)
    begin
        alloc_result_t expd;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result transfer with nothing pending");
            end
            else
            begin
                expd = pending_results.pop_front();
                if (m_tdata[1:0] !== expd.status)
                begin
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_tdata[1:0], expd.status));
                end
                if (m_tdata[33:2] !== expd.frame_address)
                begin
                    report_mismatch($sformatf("frame_address %h, want %h",
                                              m_tdata[33:2], expd.frame_address));
                end
                if (m_tdata[54:34] !== expd.free_frames)
                begin
                    report_mismatch($sformatf("free_frames %0d, want %0d",
                                              m_tdata[54:34], expd.free_frames));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Corner cases: empty total, untouched store after a total change, the largest total.
    task automatic test_directed();
        write_total(21'd0);
        send_command(OP_INIT, 32'd0, 32'd0);
        send_command(OP_FREE, 32'd0, 32'd0);
        send_command(OP_ALLOC, 32'd0, 32'd0);
        send_command(OP_SPARE5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(OP_SPARE6, 32'd0, 32'd0);
        send_command(OP_SPARE7, 32'h5555_AAAA, 32'hAAAA_5555);
        // A new total after initialize leaves every bit set, so allocate finds nothing.
        write_total(21'd64);
        send_command(OP_ALLOC, 32'd0, 32'd0);
        send_command(OP_INIT, 32'd0, 32'd0);
        send_command(OP_RELEASE, 32'd0, 32'd0);
        send_command(OP_RELEASE, 32'h0000_5FFF, 32'd1);
        send_command(OP_RELEASE, 32'h0000_2000, 32'h0000_AFFF);
        send_command(OP_ALLOC, 32'd0, 32'd0);
        send_command(OP_ALLOC, 32'd0, 32'd0);
        send_command(OP_FREE, 32'h0000_3ABC, 32'd0);
        send_command(OP_FREE, 32'h0000_3000, 32'd0);
        send_command(OP_FREE, 32'hFFFF_FFFF, 32'd0);
        send_command(OP_RESERVE, 32'hFFFF_F000, 32'hFFFF_FFFF);
        send_command(OP_RESERVE, 32'd100, 32'd8000);
        send_command(OP_RELEASE, 32'd0, 32'hFFFF_FFFF);
        // A smaller total after every frame is released; allocate then takes frame zero.
        write_total(21'd16);
        send_command(OP_ALLOC, 32'd0, 32'd0);
        write_total(21'h1F_FFFF);
        send_command(OP_INIT, 32'd0, 32'd0);
        send_command(OP_RELEASE, 32'hFFFF_F000, 32'd4096);
        send_command(OP_ALLOC, 32'd0, 32'd0);
        send_command(OP_ALLOC, 32'd0, 32'd0);
        send_command(OP_RELEASE, 32'hFFFF_E123, 32'h0000_1000);
        send_command(OP_RESERVE, 32'd0, 32'hFFFF_FFFF);
        send_command(OP_FREE, 32'hFFFF_F000, 32'd0);
        send_command(OP_ALLOC, 32'd0, 32'd0);
    endtask

    // Random traffic on one total: initialize, open the whole map, then mixed commands.
    task automatic test_random_traffic(int count, int unsigned total);
        int          k;
        logic [2:0]  op;
        logic [31:0] base;
        logic [31:0] size;
        write_total(FRAME_W'(total));
        send_command(OP_INIT, 32'd0, 32'd0);
        send_command(OP_RELEASE, 32'd0, total * PAGE_BYTES);
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(99);
            if (k < 30)
            begin
                op = OP_ALLOC;
            end
            else if (k < 52)
            begin
                op = OP_FREE;
            end
            else if (k < 72)
            begin
                op = OP_RELEASE;
            end
            else if (k < 92)
            begin
                op = OP_RESERVE;
            end
            else
            begin
                op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
            end
            if ($urandom_range(99) < 15)
            begin
                base = $urandom;
                size = $urandom;
            end
            else
            begin
                base = {20'($urandom_range(0, total + 3)), 12'($urandom)};
                size = $urandom_range(0, 40 * PAGE_BYTES);
            end
            send_command(op, base, size);
        end
    endtask

    // The receiver stops for a long stretch while commands keep coming.
    task automatic test_output_backpressure();
        tx_idle_pct    = 0;
        rx_hold_cycles = 400;
        for (int n = 0; n < 30; n++)
        begin
            send_command(n % 3 == 0 ? OP_RELEASE : OP_ALLOC, 32'($urandom_range(0, 8)) << 12,
                         32'd4096);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        used_cnt       = '0;
        total_reg      = '0;
        err_count      = 0;
        cycle_count    = 0;
        rx_hold_cycles = 0;
        tx_idle_pct    = 38;
        rx_idle_pct    = 61;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_traffic(200, 1);
        test_random_traffic(200, $urandom_range(40, 700));
        tx_idle_pct = 61;
        rx_idle_pct = 38;
        test_random_traffic(200, 32);
        test_random_traffic(200, 33);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(200, 31);
        test_random_traffic(200, $urandom_range(2, 1000));
        test_output_backpressure();

        wait_idle();
        repeat (40) @(posedge clk);
        if (err_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
